>>> hdl/sqch_pkg.sv
// Shared types and constants for the square channel with frequency sweep.
// Holds the transaction payload structs, the channel state struct and the duty patterns.
// No dependencies.
package sqch_pkg;

    // Item kinds
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_DUTY_TICK = 2'd1;
    localparam logic [1:0] MODE_SWEEP_TICK = 2'd2;

    // Channel register indexes
    localparam logic [2:0] REG_SWEEP = 3'd0;
    localparam logic [2:0] REG_LENGTH_DUTY = 3'd1;
    localparam logic [2:0] REG_ENVELOPE = 3'd2;
    localparam logic [2:0] REG_FREQ_LOW = 3'd3;
    localparam logic [2:0] REG_FREQ_HIGH = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MASTER_ON = 1'b0;

    // Read-back masks
    localparam logic [7:0] RB_SWEEP_MASK = 8'h80;
    localparam logic [7:0] RB_LENGTH_MASK = 8'h3F;
    localparam logic [7:0] RB_ENVELOPE_OFF = 8'h00;
    localparam logic [7:0] RB_FREQ_LOW = 8'hFF;
    localparam logic [7:0] RB_FREQ_HIGH_MASK = 8'hBF;
    localparam logic [7:0] RB_UNMAPPED = 8'hFF;
    localparam logic [7:0] RB_NONE = 8'h00;

    localparam logic [11:0] TIMER_RESET = 12'h800;
    localparam logic [6:0] LENGTH_FULL = 7'd64;

    // Bit i of a pattern is the level at duty step i
    localparam logic [3:0][7:0] DUTY_PATTERNS = '{
        8'b0111_1110,
        8'b1110_0001,
        8'b1000_0001,
        8'b1000_0000
    };

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] tick_cycles;
    } sqch_in_t;

    typedef struct packed {
        logic [7:0]  read_back;
        logic        duty_level;
        logic        channel_active;
        logic [11:0] current_frequency;
        logic [6:0]  length_left;
        logic        length_gate;
    } sqch_out_t;

    typedef struct packed {
        logic [11:0] freq_code;
        logic [1:0]  pattern_select;
        logic [2:0]  pattern_step;
        logic [11:0] timer_count;
        logic [11:0] timer_period;
        logic [2:0]  sweep_period;
        logic        sweep_down;
        logic [2:0]  sweep_shift;
        logic [11:0] sweep_shadow;
        logic [2:0]  sweep_count;
        logic        sweep_on;
        logic [6:0]  length_count;
        logic        length_on;
        logic        chan_on;
    } sqch_state_t;

    // Power-up channel state: everything clear but the duty timer
    localparam sqch_state_t STATE_RESET = '{
        freq_code:      12'd0,
        pattern_select: 2'd0,
        pattern_step:   3'd0,
        timer_count:    TIMER_RESET,
        timer_period:   TIMER_RESET,
        sweep_period:   3'd0,
        sweep_down:     1'b0,
        sweep_shift:    3'd0,
        sweep_shadow:   12'd0,
        sweep_count:    3'd0,
        sweep_on:       1'b0,
        length_count:   7'd0,
        length_on:      1'b0,
        chan_on:        1'b0
    };

endpackage

>>> hdl/sqch_step.sv
// Next-state and result logic for one transaction of the square channel.
// Pure combinational: register writes, duty timer tick, sweep tick and trigger.
// Depends on sqch_pkg.
module sqch_step (
    input  sqch_pkg::sqch_state_t state_i,
    input  sqch_pkg::sqch_in_t    item_i,
    input  logic                  master_on_i,
    output sqch_pkg::sqch_state_t state_o,
    output sqch_pkg::sqch_out_t   result_o
);
    import sqch_pkg::*;

    function automatic logic [11:0] period_of(input logic [11:0] freq);
        // Overflowed codes hold the period at one
        period_of = freq[11] ? 12'd1 : (TIMER_RESET - freq);
    endfunction

    function automatic sqch_state_t run_sweep(input sqch_state_t st);
        sqch_state_t r;
        logic [11:0] delta;
        logic [12:0] sum;
        logic [11:0] nxt;
        r = st;
        delta = st.sweep_shadow >> st.sweep_shift;
        sum = {1'b0, st.sweep_shadow} + {1'b0, delta};
        // delta never exceeds the shadow, so the downward case cannot go below zero
        nxt = st.sweep_down ? (st.sweep_shadow - delta) : sum[11:0];
        if (nxt[11]) begin
            r.chan_on = 1'b0;
            r.sweep_on = 1'b0;
        end
        r.freq_code = nxt;
        r.sweep_shadow = nxt;
        r.sweep_count = st.sweep_period;
        r.timer_period = period_of(nxt);
        return r;
    endfunction

    sqch_state_t st;
    logic [7:0]  rb;
    logic [11:0] freq_w;
    logic signed [13:0] diff;
    logic signed [13:0] wrapped;
    logic [2:0]  count_dec;

    always_comb begin
        st = state_i;
        rb = RB_NONE;
        freq_w = state_i.freq_code;
        diff = $signed({2'b00, state_i.timer_count}) - $signed({6'b0, item_i.tick_cycles});
        wrapped = diff + $signed({2'b00, state_i.timer_period});
        count_dec = state_i.sweep_count - 3'd1;

        case (item_i.mode)
            MODE_WRITE: begin
                if (item_i.reg_index > REG_FREQ_HIGH) begin
                    rb = RB_UNMAPPED;
                end else if (!master_on_i) begin
                    case (item_i.reg_index)
                        REG_SWEEP:       rb = RB_SWEEP_MASK;
                        REG_LENGTH_DUTY: rb = RB_LENGTH_MASK;
                        REG_ENVELOPE:    rb = RB_ENVELOPE_OFF;
                        REG_FREQ_LOW:    rb = RB_FREQ_LOW;
                        default:         rb = RB_FREQ_HIGH_MASK;
                    endcase
                end else begin
                    case (item_i.reg_index)
                        REG_SWEEP: begin
                            st.sweep_period = item_i.write_data[6:4];
                            st.sweep_down = item_i.write_data[3];
                            st.sweep_shift = item_i.write_data[2:0];
                            rb = item_i.write_data | RB_SWEEP_MASK;
                        end
                        REG_LENGTH_DUTY: begin
                            st.length_count = LENGTH_FULL - {1'b0, item_i.write_data[5:0]};
                            st.pattern_select = item_i.write_data[7:6];
                            rb = item_i.write_data | RB_LENGTH_MASK;
                        end
                        REG_ENVELOPE: begin
                            rb = item_i.write_data;
                        end
                        REG_FREQ_LOW: begin
                            st.freq_code = {state_i.freq_code[11:8], item_i.write_data};
                            st.freq_code[11] = 1'b0;
                            st.timer_period = period_of(st.freq_code);
                            rb = RB_FREQ_LOW;
                        end
                        default: begin
                            freq_w = {1'b0, item_i.write_data[2:0], state_i.freq_code[7:0]};
                            st.freq_code = freq_w;
                            st.timer_period = period_of(freq_w);
                            if (item_i.write_data[7]) begin
                                if (state_i.length_count == 7'd0) begin
                                    st.length_count = LENGTH_FULL;
                                end
                                st.chan_on = 1'b1;
                                st.pattern_step = 3'd0;
                                st.timer_count = st.timer_period;
                                st.sweep_shadow = freq_w;
                                st.sweep_count = state_i.sweep_period;
                                st.sweep_on = (state_i.sweep_period != 3'd0) ||
                                              (state_i.sweep_shift != 3'd0);
                                if (state_i.sweep_shift != 3'd0) begin
                                    st = run_sweep(st);
                                end
                            end
                            st.length_on = item_i.write_data[6];
                            rb = item_i.write_data | RB_FREQ_HIGH_MASK;
                        end
                    endcase
                end
            end
            MODE_DUTY_TICK: begin
                if (item_i.tick_cycles != 8'd0) begin
                    if (diff <= 14'sd0) begin
                        // Reload with the period added back, floor of one
                        if (wrapped < 14'sd1) begin
                            st.timer_count = 12'd1;
                        end else begin
                            st.timer_count = wrapped[11:0];
                        end
                        st.pattern_step = state_i.pattern_step + 3'd1;
                    end else begin
                        st.timer_count = diff[11:0];
                    end
                end
            end
            MODE_SWEEP_TICK: begin
                if (state_i.sweep_on && (state_i.sweep_period != 3'd0)) begin
                    if (count_dec != 3'd0) begin
                        st.sweep_count = count_dec;
                    end else begin
                        st = run_sweep(state_i);
                    end
                end
            end
            default: begin
                st = state_i;
            end
        endcase
    end

    assign state_o = st;
    assign result_o.read_back = rb;
    assign result_o.duty_level = DUTY_PATTERNS[st.pattern_select][st.pattern_step];
    assign result_o.channel_active = st.chan_on;
    assign result_o.current_frequency = st.freq_code;
    assign result_o.length_left = st.length_count;
    assign result_o.length_gate = st.length_on;

endmodule

>>> hdl/square_channel_with_sweep.sv
// Top level of the square channel with frequency sweep.
// Input register, channel state, result register and the APB configuration port.
// Depends on sqch_pkg and sqch_step.
//
// Usage:
//   Items arrive on the s_ channel (valid/ready) as sqch_in_t: a channel
//   register write, a duty clock tick or a sweep tick. Each item yields
//   exactly one result on the m_ channel as sqch_out_t: read-back byte,
//   duty level, channel-on, frequency code, length count and length gate.
//   The input register takes the item at the accepting edge; the edge on which
//   it advances runs the state update and captures the result in one pass of
//   combinational logic into the result register. Throughput is one item per
//   cycle while the result register is free or m_ready is high, set by that
//   single pass on the state registers.
//   When m_ready is low the result register holds and the input register
//   still takes one more transaction; s_ready drops once both are full.
//   The APB port holds sound_master_on at byte address 0; with it low,
//   channel register writes change nothing and return fixed masks.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   channel state to its power-up values; master enable resets to off.
module square_channel_with_sweep (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sqch_pkg::sqch_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sqch_pkg::sqch_out_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sqch_pkg::*;

    logic        in_valid_reg;
    sqch_in_t    in_item_reg;
    logic        out_valid_reg;
    sqch_out_t   out_item_reg;
    sqch_state_t state_reg;
    sqch_state_t state_next;
    sqch_out_t   result_next;
    logic        master_on_reg;
    logic        advance;
    logic        cfg_write;

    sqch_step u_step (
        .state_i     (state_reg),
        .item_i      (in_item_reg),
        .master_on_i (master_on_reg),
        .state_o     (state_next),
        .result_o    (result_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // APB: one register, byte offset within it ignored
    assign cfg_write = psel && penable && pwrite && (paddr[2] == CFG_MASTER_ON);
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_on_reg <= 1'b0;
        end else if (cfg_write) begin
            master_on_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == CFG_MASTER_ON) begin
            prdata = {31'd0, master_on_reg};
        end
    end

endmodule

>>> sim/square_channel_with_sweep_tb.sv
`timescale 1ns / 100ps
// Testbench for square_channel_with_sweep: directed and random register writes and ticks,
// checked transaction by transaction against a scoreboard that tracks the channel state.
// Depends on sqch_pkg and the square_channel_with_sweep RTL.
module square_channel_with_sweep_tb;
    import sqch_pkg::*;

    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;
    // master enable sits at byte address 4 * CFG_MASTER_ON
    localparam logic [2:0] ADDR_MASTER_ON  = 3'd0;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;

    class sweep_scoreboard;
        // bit n of entry s is the wave level at duty step n of pattern s
        localparam bit [3:0][7:0] WAVE = {8'b0111_1110, 8'b1110_0001,
                                          8'b1000_0001, 8'b1000_0000};
        sqch_state_t st;
        bit          master_on;
        sqch_out_t   pending_results[$];
        int          errors;

        function new();
            st = '0;
            st.timer_count  = 12'd2048;
            st.timer_period = 12'd2048;
            master_on = 1'b0;
            errors = 0;
        endfunction

        function void retune();
            st.timer_period = (st.freq_code > 12'd2047) ? 12'd1 : 12'd2048 - st.freq_code;
        endfunction

        function void run_sweep();
            logic [11:0] delta;
            logic [11:0] nxt;
            delta = st.sweep_shadow >> st.sweep_shift;
            nxt = st.sweep_down ? st.sweep_shadow - delta : st.sweep_shadow + delta;
            if (nxt > 12'd2047) begin
                st.chan_on  = 1'b0;
                st.sweep_on = 1'b0;
            end
            st.freq_code    = nxt;
            st.sweep_shadow = nxt;
            st.sweep_count  = st.sweep_period;
            retune();
        endfunction

        function void note(sqch_in_t it);
            sqch_out_t   want;
            logic [7:0]  v;
            logic [2:0]  cnt_next;
            int          r;
            want = '0;
            v = it.write_data;
            case (it.mode)
                MODE_WRITE: begin
                    if (it.reg_index > REG_FREQ_HIGH) begin
                        want.read_back = 8'hFF;
                    end else if (!master_on) begin
                        case (it.reg_index)
                            REG_SWEEP:       want.read_back = 8'h80;
                            REG_LENGTH_DUTY: want.read_back = 8'h3F;
                            REG_ENVELOPE:    want.read_back = 8'h00;
                            REG_FREQ_LOW:    want.read_back = 8'hFF;
                            default:         want.read_back = 8'hBF;
                        endcase
                    end else begin
                        case (it.reg_index)
                            REG_SWEEP: begin
                                st.sweep_period = v[6:4];
                                st.sweep_down   = v[3];
                                st.sweep_shift  = v[2:0];
                                want.read_back  = v | 8'h80;
                            end
                            REG_LENGTH_DUTY: begin
                                st.length_count   = 7'd64 - v[5:0];
                                st.pattern_select = v[7:6];
                                want.read_back    = v | 8'h3F;
                            end
                            REG_ENVELOPE: want.read_back = v;
                            REG_FREQ_LOW: begin
                                st.freq_code = {1'b0, st.freq_code[10:8], v};
                                retune();
                                want.read_back = 8'hFF;
                            end
                            default: begin
                                st.freq_code = {1'b0, v[2:0], st.freq_code[7:0]};
                                retune();
                                if (v[7]) begin
                                    if (st.length_count == 7'd0) st.length_count = 7'd64;
                                    st.chan_on      = 1'b1;
                                    st.pattern_step = 3'd0;
                                    st.timer_count  = st.timer_period;
                                    st.sweep_shadow = st.freq_code;
                                    st.sweep_count  = st.sweep_period;
                                    st.sweep_on = (st.sweep_period != 3'd0) ||
                                                  (st.sweep_shift != 3'd0);
                                    if (st.sweep_shift != 3'd0) run_sweep();
                                end
                                st.length_on   = v[6];
                                want.read_back = v | 8'hBF;
                            end
                        endcase
                    end
                end
                MODE_DUTY_TICK: begin
                    if (it.tick_cycles != 8'd0) begin
                        r = int'(st.timer_count) - int'(it.tick_cycles);
                        // at most one duty step per tick, reload floored at 1
                        if (r <= 0) begin
                            r += int'(st.timer_period);
                            if (r < 1) r = 1;
                            st.pattern_step = st.pattern_step + 3'd1;
                        end
                        st.timer_count = r[11:0];
                    end
                end
                MODE_SWEEP_TICK: begin
                    if (st.sweep_on && st.sweep_period != 3'd0) begin
                        cnt_next = st.sweep_count - 3'd1;
                        if (cnt_next != 3'd0) st.sweep_count = cnt_next;
                        else run_sweep();
                    end
                end
                default: ;
            endcase
            want.duty_level        = WAVE[st.pattern_select][st.pattern_step];
            want.channel_active    = st.chan_on;
            want.current_frequency = st.freq_code;
            want.length_left       = st.length_count;
            want.length_gate       = st.length_on;
            pending_results.push_back(want);
        endfunction

        task report(string msg);
            if (errors < 100) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(sqch_out_t got);
            sqch_out_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result %h with nothing pending", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.read_back !== want.read_back)
                report($sformatf("read_back %h, want %h", got.read_back, want.read_back));
            if (got.duty_level !== want.duty_level)
                report($sformatf("duty_level %b, want %b", got.duty_level, want.duty_level));
            if (got.channel_active !== want.channel_active)
                report($sformatf("channel_active %b, want %b",
                                 got.channel_active, want.channel_active));
            if (got.current_frequency !== want.current_frequency)
                report($sformatf("current_frequency %h, want %h",
                                 got.current_frequency, want.current_frequency));
            if (got.length_left !== want.length_left)
                report($sformatf("length_left %0d, want %0d", got.length_left, want.length_left));
            if (got.length_gate !== want.length_gate)
                report($sformatf("length_gate %b, want %b", got.length_gate, want.length_gate));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    sqch_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    sqch_out_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sweep_scoreboard sb;
    bit calm;
    int quiet_cycles;

    square_channel_with_sweep dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // note inputs before checking so a same-cycle result would still find its entry
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note(s_data);
            if (m_valid && m_ready) sb.check(m_data);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            m_ready = calm || ($urandom_range(99) >= 8);
        end
    end

    function automatic sqch_in_t reg_item(logic [2:0] idx, logic [7:0] data);
        sqch_in_t    it;
        logic [31:0] rnd;
        rnd = $urandom;
        it = rnd[$bits(sqch_in_t)-1:0];
        it.mode       = MODE_WRITE;
        it.reg_index  = idx;
        it.write_data = data;
        return it;
    endfunction

    function automatic sqch_in_t tick_item(logic [1:0] mode, logic [7:0] cycles);
        sqch_in_t    it;
        logic [31:0] rnd;
        rnd = $urandom;
        it = rnd[$bits(sqch_in_t)-1:0];
        it.mode        = mode;
        it.tick_cycles = cycles;
        return it;
    endfunction

    function automatic sqch_in_t random_item();
        sqch_in_t it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)      it = reg_item(REG_SWEEP, 8'($urandom));
        else if (pick < 20) it = reg_item(REG_LENGTH_DUTY, 8'($urandom));
        else if (pick < 24) it = reg_item(REG_ENVELOPE, 8'($urandom));
        else if (pick < 34) it = reg_item(REG_FREQ_LOW, 8'($urandom));
        else if (pick < 48) it = reg_item(REG_FREQ_HIGH, 8'($urandom));
        else if (pick < 78) it = tick_item(MODE_DUTY_TICK, 8'($urandom));
        else if (pick < 95) it = tick_item(MODE_SWEEP_TICK, 8'($urandom));
        else if (pick < 97) it = tick_item(MODE_UNUSED, 8'($urandom));
        else it = reg_item(3'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)),
                           8'($urandom));
        return it;
    endfunction

    task automatic push_item(sqch_in_t it);
        while (!calm && $urandom_range(99) < 8) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drain(int tail);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (tail) @(negedge aclk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // change master enable only with the pipeline empty
    task automatic set_master(bit on);
        logic [31:0] rd;
        s_valid = 1'b0;
        wait_drain(4);
        apb_xfer(1'b1, ADDR_MASTER_ON, {31'b0, on}, rd);
        sb.master_on = on;
        apb_xfer(1'b0, ADDR_MASTER_ON, 32'b0, rd);
        if (rd[0] !== on) sb.report($sformatf("master enable reads %b, want %b", rd[0], on));
    endtask

    initial begin
        sb = new();
        calm = 1'b0;
        quiet_cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // master off: writes are dropped and masks come back
        set_master(1'b0);
        push_item(reg_item(REG_SWEEP, 8'hFF));
        push_item(reg_item(REG_LENGTH_DUTY, 8'hFF));
        push_item(reg_item(REG_ENVELOPE, 8'hFF));
        push_item(reg_item(REG_FREQ_LOW, 8'hFF));
        push_item(reg_item(REG_FREQ_HIGH, 8'hFF));
        push_item(reg_item(REG_UNMAPPED_LO, 8'h00));
        push_item(tick_item(MODE_DUTY_TICK, 8'd10));
        push_item(tick_item(MODE_SWEEP_TICK, 8'd1));

        set_master(1'b1);
        // trigger with the length count still zero
        push_item(reg_item(REG_FREQ_HIGH, 8'h80));
        push_item(reg_item(REG_ENVELOPE, 8'h00));
        push_item(reg_item(REG_ENVELOPE, 8'hFF));
        push_item(reg_item(REG_LENGTH_DUTY, 8'h00));
        push_item(reg_item(REG_LENGTH_DUTY, 8'hFF));
        push_item(reg_item(REG_FREQ_LOW, 8'hFF));
        push_item(reg_item(REG_FREQ_HIGH, 8'h47));
        // upward sweep from the top code overflows on trigger, period pinned to 1
        push_item(reg_item(REG_SWEEP, 8'h01));
        push_item(reg_item(REG_FREQ_HIGH, 8'h87));
        push_item(tick_item(MODE_DUTY_TICK, 8'd0));
        push_item(tick_item(MODE_DUTY_TICK, 8'd255));
        push_item(tick_item(MODE_DUTY_TICK, 8'd1));
        push_item(tick_item(MODE_SWEEP_TICK, 8'd0));
        push_item(reg_item(REG_SWEEP, 8'h00));
        push_item(reg_item(REG_FREQ_LOW, 8'h00));
        push_item(reg_item(REG_FREQ_HIGH, 8'h80));
        // sweep armed with a zero count, then the counter wraps on the next tick
        push_item(reg_item(REG_SWEEP, 8'h01));
        push_item(reg_item(REG_FREQ_HIGH, 8'h84));
        push_item(reg_item(REG_SWEEP, 8'h11));
        push_item(tick_item(MODE_SWEEP_TICK, 8'd0));
        push_item(reg_item(REG_SWEEP, 8'h7F));
        push_item(tick_item(MODE_SWEEP_TICK, 8'd0));
        push_item(tick_item(MODE_UNUSED, 8'd5));
        push_item(reg_item(REG_UNMAPPED_HI, 8'hAA));

        for (int i = 0; i < 450; i++) begin
            calm = (i >= 150) && (i < 300);
            push_item(random_item());
        end
        calm = 1'b0;
        set_master(1'b0);
        for (int i = 0; i < 60; i++) push_item(random_item());
        set_master(1'b1);
        for (int i = 0; i < 90; i++) push_item(random_item());
        s_valid = 1'b0;

        wait_drain(TAIL_CYCLES);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
